// ===== sv/cnr_pkg.sv =====
// Shared types and constants for the chunk neighbor relocate block.
// No dependencies.
package cnr_pkg;

	localparam int CNR_NUM_CHUNKS = 1024;
	localparam int CNR_CHUNK_EDGE = 4;
	localparam int POS_W = 8;
	localparam int CHUNK_W = 10;
	localparam int SIDE_W = 3;
	localparam int LINK_SLOTS = 6;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_RELOCATE = 1'b1;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// controller to datapath
	typedef struct packed {
		logic wr;
		logic load;
		logic rd;
		logic hop;
		logic next_axis;
		logic fail;
		logic emit;
	} cnr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic below;
		logic above;
		logic cur_bad;
		logic link_bad;
		logic last_axis;
		logic out_free;
	} cnr_stat_t;

endpackage

// ===== sv/cnr_ctrl.sv =====
// Controller for the chunk neighbor relocate block: walk sequencing.
// Depends on cnr_pkg.
module cnr_ctrl
	import cnr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      opcode,
	output logic      in_stall,
	input  cnr_stat_t stat,
	output cnr_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_WALK = 4'b0010,
		S_LINK = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (opcode == OP_RELOCATE) begin
						cmd.load = 1'b1;
						state_d = S_WALK;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			S_WALK: begin
				if (stat.below || stat.above) begin
					if (stat.cur_bad) begin
						cmd.fail = 1'b1;
						state_d = S_EMIT;
					end else begin
						cmd.rd = 1'b1;
						state_d = S_LINK;
					end
				end else if (stat.last_axis) begin
					state_d = S_EMIT;
				end else begin
					cmd.next_axis = 1'b1;
				end
			end
			S_LINK: begin
				if (stat.link_bad) begin
					cmd.fail = 1'b1;
					state_d = S_EMIT;
				end else begin
					cmd.hop = 1'b1;
					state_d = S_WALK;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/cnr_dp.sv =====
// Datapath for the chunk neighbor relocate block: link memory, walk registers,
// result register. Depends on cnr_pkg.
module cnr_dp
	import cnr_pkg::*;
#(
	parameter int NUM_CHUNKS = CNR_NUM_CHUNKS,
	parameter int CHUNK_EDGE = CNR_CHUNK_EDGE
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cnr_cmd_t                 cmd,
	output cnr_stat_t                stat,
	input  logic [CHUNK_W-1:0]       chunk_id,
	input  logic [SIDE_W-1:0]        side_sel,
	input  logic [CHUNK_W-1:0]       link_target,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [CHUNK_W-1:0]       result_chunk,
	output logic signed [POS_W-1:0]  out_x,
	output logic signed [POS_W-1:0]  out_y,
	output logic signed [POS_W-1:0]  out_z
);

	localparam int DEPTH = NUM_CHUNKS * LINK_SLOTS;
	localparam int AW = $clog2(DEPTH);
	localparam logic signed [POS_W-1:0] EDGE_S = POS_W'(CHUNK_EDGE);

	logic [CHUNK_W-1:0] mem [DEPTH];

	logic [CHUNK_W-1:0]      cur_q;
	logic [CHUNK_W-1:0]      link_q;
	logic signed [POS_W-1:0] px_q, py_q, pz_q;
	axis_t                   axis_q;
	logic                    ok_q;
	logic                    out_valid_q;
	logic [CHUNK_W-1:0]      res_chunk_q;
	logic signed [POS_W-1:0] res_x_q, res_y_q, res_z_q;

	logic signed [POS_W-1:0] coord;
	logic signed [POS_W-1:0] coord_next;
	logic [SIDE_W-1:0]       slot;
	logic [31:0]             rd_addr_w;
	logic [31:0]             wr_addr_w;
	logic                    wr_en;

	always_comb begin
		unique case (axis_q)
			AXIS_X:  coord = px_q;
			AXIS_Y:  coord = py_q;
			AXIS_Z:  coord = pz_q;
			default: coord = pz_q;
		endcase
	end

	assign stat.below = coord[POS_W-1];
	assign stat.above = (coord >= EDGE_S);
	assign stat.cur_bad = ({22'd0, cur_q} >= 32'(NUM_CHUNKS));
	assign stat.link_bad = (link_q == '0) || ({22'd0, link_q} >= 32'(NUM_CHUNKS));
	assign stat.last_axis = (axis_q == AXIS_Z);
	assign stat.out_free = !out_valid_q || !out_stall;

	// minus slot is even, plus slot odd
	assign slot = {axis_q, stat.above};
	assign rd_addr_w = {22'd0, cur_q} * 32'(LINK_SLOTS) + {29'd0, slot};
	assign wr_addr_w = {22'd0, chunk_id} * 32'(LINK_SLOTS) + {29'd0, side_sel};
	assign wr_en = cmd.wr && ({29'd0, side_sel} < 32'(LINK_SLOTS))
		&& ({22'd0, chunk_id} < 32'(NUM_CHUNKS));

	assign coord_next = stat.below ? (coord + EDGE_S) : (coord - EDGE_S);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(wr_addr_w)] <= link_target;
		end
		if (cmd.rd) begin
			link_q <= mem[AW'(rd_addr_w)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= AXIS_X;
			ok_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				axis_q <= AXIS_X;
				ok_q <= 1'b1;
			end else if (cmd.next_axis) begin
				axis_q <= axis_t'(axis_q + 2'd1);
			end
			if (cmd.fail) begin
				ok_q <= 1'b0;
			end
			// hold the result beat until taken
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= chunk_id;
			px_q <= pos_x;
			py_q <= pos_y;
			pz_q <= pos_z;
		end else if (cmd.hop) begin
			cur_q <= link_q;
			unique case (axis_q)
				AXIS_X:  px_q <= coord_next;
				AXIS_Y:  py_q <= coord_next;
				AXIS_Z:  pz_q <= coord_next;
				default: pz_q <= coord_next;
			endcase
		end
		if (cmd.emit) begin
			res_chunk_q <= ok_q ? cur_q : '0;
			res_x_q <= px_q;
			res_y_q <= py_q;
			res_z_q <= pz_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result_chunk = res_chunk_q;
	assign out_x = res_x_q;
	assign out_y = res_y_q;
	assign out_z = res_z_q;

endmodule

// ===== sv/chunk_neighbor_relocate_core.sv =====
// Top level of the chunk neighbor relocate block: controller plus datapath.
// Depends on cnr_pkg, cnr_ctrl, cnr_dp.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------------
//  in      | in_valid / in_stall | opcode, chunk_id, side_sel, link_target, pos_*
//  out     | out_valid/out_stall | result_chunk, out_x, out_y, out_z
//
// A link write is done in the idle state. A query is accepted, then walk checks run
// per axis (X, Y, Z, all three unless a link or the current chunk is missing or bad):
// a coordinate outside the chunk starts a registered read of the link memory and
// then a hop to the linked chunk; the walk ends by loading the result register.
// Reset clears control only; the link memory holds garbage until written.
// A finished result waits in the output register; new items are taken meanwhile,
// and a query only stalls at its end while the previous result is still held.
module chunk_neighbor_relocate_core
	import cnr_pkg::*;
#(
	parameter int NUM_CHUNKS = CNR_NUM_CHUNKS,
	parameter int CHUNK_EDGE = CNR_CHUNK_EDGE
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic [CHUNK_W-1:0]       chunk_id,
	input  logic [SIDE_W-1:0]        side_sel,
	input  logic [CHUNK_W-1:0]       link_target,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [CHUNK_W-1:0]       result_chunk,
	output logic signed [POS_W-1:0]  out_x,
	output logic signed [POS_W-1:0]  out_y,
	output logic signed [POS_W-1:0]  out_z
);

	cnr_cmd_t  cmd;
	cnr_stat_t stat;

	cnr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	cnr_dp #(
		.NUM_CHUNKS (NUM_CHUNKS),
		.CHUNK_EDGE (CHUNK_EDGE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.chunk_id     (chunk_id),
		.side_sel     (side_sel),
		.link_target  (link_target),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_chunk (result_chunk),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z)
	);

endmodule
